@@ design/assert_macros.svh @@
// Assertion helpers: clocked on clk; QET_ASSERT is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define QET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked while reset is applied.
`define QET_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/qet_pkg.sv @@
package qet_pkg;

  localparam int LINE_COUNT_DEF = 64;

  localparam int FUNC_W  = 3;
  localparam int LINE_W  = 6;
  localparam int EPOCH_W = 64;
  localparam int CNT_W   = 7;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 88;

  localparam logic [FUNC_W-1:0] FUNC_ATTACH  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENTER   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXIT    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STAMP   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_FIGURES = 3'd6;

  // result word, low bits last
  typedef struct packed {
    logic               pad;
    logic [CNT_W-1:0]   inside_count;
    logic [CNT_W-1:0]   registered_count;
    logic               all_clear;
    logic [EPOCH_W-1:0] new_stamp;
    logic               is_inside;
    logic               attach_ok;
    logic [LINE_W-1:0]  assigned_line;
  } res_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic scan_step;
    logic finish_query;
    logic finish_scan;
  } qet_cmd_t;

  typedef struct packed {
    logic out_free;
    logic req_query;
    logic req_scan;
    logic clear_last;
    logic scan_last;
  } qet_sts_t;

endpackage

@@ design/qet_ram.sv @@
module qet_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/qet_ctrl.sv @@
module qet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  qet_pkg::qet_sts_t sts,
  output qet_pkg::qet_cmd_t cmd
);

  import qet_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_QUERY = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.accept = accept;
        if (accept && sts.req_query) begin
          state_nxt = ST_QUERY;
        end else if (accept && sts.req_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_QUERY: begin
        cmd.finish_query = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.finish_scan = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/qet_dp.sv @@
module qet_dp #(
  parameter int LINE_COUNT = qet_pkg::LINE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [qet_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [qet_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [qet_pkg::OUT_DATA_W-1:0] out_tdata,
  input  qet_pkg::qet_cmd_t              cmd,
  output qet_pkg::qet_sts_t              sts
);

  import qet_pkg::*;

  localparam int AW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int CW = $clog2(LINE_COUNT + 1);

  logic [FUNC_W-1:0]  in_func;
  logic [LINE_W-1:0]  in_line;
  logic               in_held;
  logic [EPOCH_W-1:0] in_stamp;
  logic               in_usable;

  logic [CW-1:0]      attached_r, attached_nxt;
  logic [EPOCH_W-1:0] seq_r, seq_nxt;
  logic [FUNC_W-1:0]  func_r;
  logic               usable_r;
  logic [EPOCH_W-1:0] stamp_r;
  logic [AW-1:0]      ptr_r;
  logic               pend_r;
  logic               clear_acc_r, clear_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_tvalid_r;
  res_t               out_tdata_r, res_nxt;
  logic               load;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [EPOCH_W-1:0] ram_wdata, epoch;
  logic               epoch_set;

  assign in_func   = in_tuser[2:0];
  assign in_held   = in_tuser[3];
  assign in_line   = in_tdata[5:0];
  assign in_stamp  = in_tdata[69:6];
  assign in_usable = in_held && (32'(in_line) < 32'(LINE_COUNT));

  qet_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (LINE_COUNT)
  ) u_epochs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (epoch)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    if (cmd.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd.accept && in_usable &&
                 (in_func == FUNC_ENTER || in_func == FUNC_EXIT)) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(in_line);
      ram_wdata = (in_func == FUNC_ENTER) ? seq_r : '0;
    end
  end

  assign ram_raddr = cmd.accept ? AW'(in_line) : ptr_r;

  assign epoch_set = (epoch != '0);
  assign clear_nxt = clear_acc_r & ~(pend_r & epoch_set & (epoch < stamp_r));
  assign cnt_nxt   = cnt_r + CW'(pend_r & epoch_set);

  assign sts.out_free   = !out_tvalid_r || out_tready;
  assign sts.req_query  = (in_func == FUNC_QUERY);
  assign sts.req_scan   = (in_func == FUNC_CLEAR || in_func == FUNC_FIGURES) &&
                          (attached_r != '0);
  assign sts.clear_last = (ptr_r == AW'(LINE_COUNT - 1));
  assign sts.scan_last  = (ptr_r == AW'(attached_r - CW'(1)));

  always_comb begin
    attached_nxt = attached_r;
    seq_nxt      = seq_r;
    res_nxt      = '0;
    load         = 1'b0;
    if (cmd.accept && !sts.req_query && !sts.req_scan) begin
      load = 1'b1;
      case (in_func)
        FUNC_ATTACH: begin
          if (in_held) begin
            res_nxt.assigned_line = in_line;
            res_nxt.attach_ok     = 1'b1;
          end else if (attached_r < CW'(LINE_COUNT)) begin
            res_nxt.assigned_line = LINE_W'(attached_r);
            res_nxt.attach_ok     = 1'b1;
            attached_nxt          = attached_r + CW'(1);
          end
        end
        FUNC_STAMP: begin
          seq_nxt           = seq_r + EPOCH_W'(1);
          res_nxt.new_stamp = seq_nxt;
        end
        FUNC_CLEAR: begin
          res_nxt.all_clear = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.finish_query) begin
      load              = 1'b1;
      res_nxt.is_inside = usable_r && epoch_set;
    end else if (cmd.finish_scan) begin
      load = 1'b1;
      if (func_r == FUNC_CLEAR) begin
        res_nxt.all_clear = clear_nxt;
      end else begin
        res_nxt.registered_count = CNT_W'(attached_r);
        res_nxt.inside_count     = CNT_W'(cnt_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r   <= '0;
      seq_r        <= EPOCH_W'(1);
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      attached_r <= attached_nxt;
      seq_r      <= seq_nxt;
      pend_r     <= cmd.scan_step;
      if (cmd.accept) begin
        ptr_r <= '0;
      end else if (cmd.clear_step || cmd.scan_step) begin
        ptr_r <= ptr_r + AW'(1);
      end
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r      <= in_func;
      usable_r    <= in_usable;
      stamp_r     <= in_stamp;
      clear_acc_r <= 1'b1;
      cnt_r       <= '0;
    end else begin
      clear_acc_r <= clear_nxt;
      cnt_r       <= cnt_nxt;
    end
    if (load) begin
      out_tdata_r <= res_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ design/quiescent_epoch_tracker_top.sv @@
// Quiescent epoch tracker: one result per request, taken one request at a
// time. Attach, enter, exit, stamp and unused codes have their result
// registered in the cycle after the request is taken; the inside query first
// waits on a registered read of the epoch table; clear check and figures step
// through the n attached lines and a drain step (n = 0: answered like the
// simple codes), since the single read port of the epoch table supplies one
// line per cycle. A new request is taken only while the output register is
// empty or being read in the same cycle, so a stalled result holds off the input.
// After reset the table is zeroed one line per cycle, with in_tready low.
module quiescent_epoch_tracker_top #(
  parameter int LINE_COUNT = qet_pkg::LINE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [qet_pkg::IN_DATA_W-1:0]  in_tdata,   // line[5:0], stamp_value[69:6], pad
  input  logic [qet_pkg::IN_USER_W-1:0]  in_tuser,   // func[2:0], line_valid[3]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [qet_pkg::OUT_DATA_W-1:0] out_tdata   // assigned_line[5:0], attach_ok[6],
                                                     // is_inside[7], new_stamp[71:8],
                                                     // all_clear[72],
                                                     // registered_count[79:73],
                                                     // inside_count[86:80], pad
);

  import qet_pkg::*;

  qet_cmd_t cmd;
  qet_sts_t sts;

  qet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qet_dp #(
    .LINE_COUNT (LINE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ design/qet_checker.sv @@
`include "assert_macros.svh"

module qet_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [qet_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [qet_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [qet_pkg::OUT_DATA_W-1:0] out_tdata
);

  import qet_pkg::*;

  logic in_acc;
  logic one_cycle_req;
  logic write_req;
  logic held_attach;

  assign in_acc        = in_tvalid && in_tready;
  assign write_req     = in_acc &&
                         (in_tuser[2:0] == FUNC_ENTER || in_tuser[2:0] == FUNC_EXIT);
  assign one_cycle_req = in_acc &&
                         (in_tuser[2:0] == FUNC_ATTACH || in_tuser[2:0] == FUNC_ENTER ||
                          in_tuser[2:0] == FUNC_EXIT || in_tuser[2:0] == FUNC_STAMP);
  assign held_attach   = in_acc && (in_tuser[2:0] == FUNC_ATTACH) && in_tuser[3];

  `QET_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result valid right after reset")
  `QET_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `QET_ASSERT(a_fast_req, one_cycle_req |=> out_tvalid, "single-cycle request gave no result")
  `QET_ASSERT(a_write_zero, write_req |=> out_tdata == '0, "enter or exit result not zero")
  `QET_ASSERT(a_attach_echo, held_attach |=> out_tdata[6] && out_tdata[5:0] == $past(in_tdata[5:0]), "attach did not echo held line")

endmodule

bind quiescent_epoch_tracker_top qet_checker u_qet_checker (.*);

@@ sim/tb_quiescent_epoch_tracker_top.sv @@
`timescale 1ns / 100ps

module tb_quiescent_epoch_tracker_top;
  import qet_pkg::*;

  localparam int LINE_COUNT = LINE_COUNT_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
  localparam int MAX_WAIT = 16;
  localparam int SCAN_SETTLE = LINE_COUNT + 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [EPOCH_W-1:0] epoch_word [LINE_COUNT];
  int unsigned lines_attached = 0;
  logic [EPOCH_W-1:0] seq_now = 64'd1;

  res_t pending_results [$];
  int error_count = 0;
  int requests_sent = 0;
  int checked_results = 0;
  int stamps_issued = 0;
  int scans_done = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int stall_left = 0;

  quiescent_epoch_tracker_top #(.LINE_COUNT(LINE_COUNT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < LINE_COUNT; i++) epoch_word[i] = '0;
  end

  function automatic res_t epoch_table_step(input logic [FUNC_W-1:0] f,
                                            input logic [LINE_W-1:0] ln, input logic lv,
                                            input logic [EPOCH_W-1:0] sv);
    res_t r;
    int unsigned span;
    int unsigned held;
    r = '0;
    held = 0;
    span = (lines_attached < LINE_COUNT) ? lines_attached : LINE_COUNT;
    case (f)
      FUNC_ATTACH: begin
        if (lv) begin
          r.assigned_line = ln;
          r.attach_ok = 1'b1;
        end else if (lines_attached < LINE_COUNT) begin
          r.assigned_line = LINE_W'(lines_attached);
          r.attach_ok = 1'b1;
          lines_attached++;
        end
      end
      FUNC_ENTER: begin
        if (lv && ln < LINE_COUNT) epoch_word[ln] = seq_now;
      end
      FUNC_EXIT: begin
        if (lv && ln < LINE_COUNT) epoch_word[ln] = '0;
      end
      FUNC_QUERY: begin
        r.is_inside = lv && ln < LINE_COUNT && epoch_word[ln] != '0;
      end
      FUNC_STAMP: begin
        seq_now = seq_now + 64'd1;
        r.new_stamp = seq_now;
        stamps_issued++;
      end
      FUNC_CLEAR: begin
        r.all_clear = 1'b1;
        for (int i = 0; i < span; i++)
          if (epoch_word[i] != '0 && epoch_word[i] < sv) r.all_clear = 1'b0;
        scans_done++;
      end
      FUNC_FIGURES: begin
        for (int i = 0; i < span; i++)
          if (epoch_word[i] != '0) held++;
        r.registered_count = CNT_W'(span);
        r.inside_count = CNT_W'(held);
        scans_done++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [EPOCH_W-1:0] got,
                                 input logic [EPOCH_W-1:0] want);
    $display("ERROR result %0d: %s got 0x%0h expected 0x%0h", checked_results, what, got, want);
    error_count++;
  endtask

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [LINE_W-1:0] ln,
                              input logic lv, input logic [EPOCH_W-1:0] sv);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, sv, ln};
    in_tuser <= {lv, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(epoch_table_step(f, ln, lv, sv));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [EPOCH_W-1:0] pick_stamp();
    case ($urandom_range(0, 7))
      0: return seq_now;
      1: return seq_now + 64'd1;
      2: return seq_now - 64'd1;
      3: return epoch_word[LINE_W'($urandom_range(0, LINE_COUNT - 1))];
      4: return '0;
      5: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic test_directed();
    send_request(FUNC_FIGURES, 6'd0, 1'b0, '0);
    send_request(FUNC_CLEAR, 6'd0, 1'b0, '1);
    send_request(FUNC_QUERY, 6'd0, 1'b0, '0);
    send_request(FUNC_ENTER, 6'd0, 1'b0, '0);
    send_request(FUNC_UNUSED, 6'h3f, 1'b1, '1);
    send_request(FUNC_ATTACH, 6'd0, 1'b0, '0);
    send_request(FUNC_ATTACH, 6'h3f, 1'b0, '0);
    send_request(FUNC_ATTACH, 6'h3f, 1'b1, '1);
    send_request(FUNC_ENTER, 6'd0, 1'b1, '0);
    send_request(FUNC_QUERY, 6'd0, 1'b1, '0);
    send_request(FUNC_QUERY, 6'd1, 1'b1, '0);
    send_request(FUNC_ENTER, 6'd40, 1'b1, '0);
    send_request(FUNC_FIGURES, 6'd0, 1'b1, '0);
    send_request(FUNC_STAMP, 6'd0, 1'b0, '0);
    send_request(FUNC_CLEAR, 6'd0, 1'b1, 64'd2);
    send_request(FUNC_CLEAR, 6'd0, 1'b1, 64'd1);
    send_request(FUNC_CLEAR, 6'd0, 1'b1, '0);
    send_request(FUNC_EXIT, 6'd0, 1'b1, '0);
    send_request(FUNC_CLEAR, 6'd0, 1'b1, '1);
    send_request(FUNC_QUERY, 6'd40, 1'b1, '0);
    send_request(FUNC_EXIT, 6'd40, 1'b0, '0);
    send_request(FUNC_QUERY, 6'd40, 1'b1, '0);
    send_request(FUNC_EXIT, 6'd40, 1'b1, '1);
    send_request(FUNC_QUERY, 6'd40, 1'b1, '0);
    send_request(FUNC_STAMP, 6'h3f, 1'b1, '1);
  endtask

  // attach_cap bounds how many lines the run hands out in this phase
  task automatic test_random_requests(input int count, input int unsigned attach_cap);
    int counted;
    int pick;
    logic [FUNC_W-1:0] f;
    logic [LINE_W-1:0] ln;
    logic lv;
    counted = 0;
    while (counted < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) f = FUNC_ATTACH;
      else if (pick < 30) f = FUNC_ENTER;
      else if (pick < 45) f = FUNC_EXIT;
      else if (pick < 62) f = FUNC_QUERY;
      else if (pick < 77) f = FUNC_STAMP;
      else if (pick < 89) f = FUNC_CLEAR;
      else if (pick < 97) f = FUNC_FIGURES;
      else f = FUNC_UNUSED;
      if (lines_attached > 0 && $urandom_range(0, 9) < 7)
        ln = LINE_W'($urandom_range(0, lines_attached - 1));
      else
        ln = LINE_W'($urandom_range(0, LINE_COUNT - 1));
      lv = $urandom_range(0, 9) != 0;
      if (f == FUNC_ATTACH && lines_attached >= attach_cap) lv = 1'b1;
      send_request(f, ln, lv, (f == FUNC_CLEAR) ? pick_stamp() : {$urandom(), $urandom()});
      if (!((f == FUNC_ENTER || f == FUNC_EXIT) && !lv)) counted++;
    end
  endtask

  task automatic test_fill_table();
    while (lines_attached < LINE_COUNT) begin
      send_request(FUNC_ATTACH, LINE_W'($urandom()), 1'b0, '0);
      if ($urandom_range(0, 3) == 0)
        send_request(FUNC_ENTER, LINE_W'(lines_attached - 1), 1'b1, '0);
    end
    repeat (3) send_request(FUNC_ATTACH, LINE_W'($urandom()), 1'b0, '0);
    send_request(FUNC_FIGURES, 6'd0, 1'b1, '0);
    send_request(FUNC_CLEAR, 6'd0, 1'b1, seq_now);
    send_request(FUNC_CLEAR, 6'd0, 1'b1, '1);
  endtask

  always @(posedge clk) begin : drive_ready
    int wait_draw;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      wait_draw = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      stall_left <= (wait_draw > 0) ? wait_draw - 1 : 0;
      out_tready <= (wait_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[EPOCH_W-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (got.assigned_line !== want.assigned_line)
          report_mismatch("assigned_line", EPOCH_W'(got.assigned_line),
                          EPOCH_W'(want.assigned_line));
        if (got.attach_ok !== want.attach_ok)
          report_mismatch("attach_ok", EPOCH_W'(got.attach_ok), EPOCH_W'(want.attach_ok));
        if (got.is_inside !== want.is_inside)
          report_mismatch("is_inside", EPOCH_W'(got.is_inside), EPOCH_W'(want.is_inside));
        if (got.new_stamp !== want.new_stamp)
          report_mismatch("new_stamp", got.new_stamp, want.new_stamp);
        if (got.all_clear !== want.all_clear)
          report_mismatch("all_clear", EPOCH_W'(got.all_clear), EPOCH_W'(want.all_clear));
        if (got.registered_count !== want.registered_count)
          report_mismatch("registered_count", EPOCH_W'(got.registered_count),
                          EPOCH_W'(want.registered_count));
        if (got.inside_count !== want.inside_count)
          report_mismatch("inside_count", EPOCH_W'(got.inside_count),
                          EPOCH_W'(want.inside_count));
      end
      checked_results++;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_requests(520, 8);
    wait_drained();
    test_fill_table();
    test_random_requests(700, LINE_COUNT);
    wait_drained();
    repeat (SCAN_SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", EPOCH_W'(pending_results.size()), '0);
    $display("covered %0d requests, %0d results checked, %0d table scans",
             requests_sent, checked_results, scans_done);
    $display("lines attached %0d of %0d, stamps issued %0d, final sequence %0d",
             lines_attached, LINE_COUNT, stamps_issued, seq_now);
    if (error_count == 0) begin
      $display("PASS quiescent_epoch_tracker_top");
    end else begin
      $display("FAIL quiescent_epoch_tracker_top");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL quiescent_epoch_tracker_top");
    $finish;
  end

endmodule
